/* design/i4q_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i4q_pkg
// Shared types, constants and helper functions of the int4 absmax quantizer.
// ----------------------------------------------------------------------------
package i4q_pkg;

   localparam int MAX_ELEMENTS = 128;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

   localparam int WEIGHT_W     = 16;
   localparam int MAG_W        = 16;
   localparam int SCALE_W      = 21;
   localparam int COUNT_W      = 8;
   localparam int BYTE_W       = 8;
   localparam int CODE_W       = 4;
   localparam int FRAC_W       = 8;
   localparam int MUL7_W       = MAG_W + 3;

   // serial divider sizing: numerator covers 7*|w|
   localparam int DIV_NUM_W    = MUL7_W;
   localparam int DIV_DEN_W    = MAG_W;
   localparam int DIV_CNT_W    = $clog2(DIV_NUM_W);

   // scale = (absmax*256 + 3) / 7 by reciprocal multiply
   localparam int SCALE_NUM_W   = MAG_W + FRAC_W;
   localparam int SCALE_RECIP_W = 25;
   localparam int SCALE_SHIFT   = 27;
   localparam int SCALE_PROD_W  = SCALE_NUM_W + SCALE_RECIP_W;

   // ceil(2^27 / 7), exact floor division by seven for any 24-bit numerator
   localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP   = SCALE_RECIP_W'(19173962);
   localparam logic [SCALE_NUM_W-1:0]   SCALE_ROUND   = SCALE_NUM_W'(3);
   localparam logic [CODE_W:0]          CODE_POS_MAX  = (CODE_W + 1)'(7);
   localparam logic [CODE_W:0]          CODE_NEG_MAX  = (CODE_W + 1)'(8);

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight;
      logic                       last_weight;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  packed_byte;
      logic [SCALE_W-1:0] scale_fixed;
      logic [COUNT_W-1:0] element_count;
      logic               last_byte;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
      logic [DIV_DEN_W-1:0] rem;
   } div_rsp_type;

   // magnitude of a signed sample; -32768 maps to 0x8000 exactly
   function automatic logic [MAG_W-1:0] abs_mag(input logic [WEIGHT_W-1:0] w);
      logic [MAG_W-1:0] m;
      m = w[WEIGHT_W-1] ? MAG_W'(~w + WEIGHT_W'(1)) : MAG_W'(w);
      return m;
   endfunction

   // rounded quotient magnitude and sign to a clamped 4-bit code
   function automatic logic [CODE_W-1:0] code_nibble(input logic [CODE_W:0] q,
                                                     input logic neg);
      logic [CODE_W:0]   nq;
      logic [CODE_W-1:0] c;
      nq = ~q + (CODE_W + 1)'(1);
      if (neg) begin
         c = (q > CODE_NEG_MAX) ? CODE_NEG_MAX[CODE_W-1:0] : nq[CODE_W-1:0];
      end else begin
         c = (q > CODE_POS_MAX) ? CODE_POS_MAX[CODE_W-1:0] : q[CODE_W-1:0];
      end
      return c;
   endfunction

endpackage

/* design/i4q_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i4q_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module i4q_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/i4q_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i4q_divider
// Restoring radix-2 divider, one quotient bit per cycle, used for the
// per-sample code computation.
// ----------------------------------------------------------------------------
module i4q_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  i4q_pkg::div_req_type      div_req,
   output i4q_pkg::div_rsp_type      div_rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [i4q_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [i4q_pkg::DIV_NUM_W-1:0]   quo_ff, quo_in;
   logic [i4q_pkg::DIV_DEN_W-1:0]   rem_ff, rem_in;
   logic [i4q_pkg::DIV_DEN_W-1:0]   den_ff, den_in;
   logic [i4q_pkg::DIV_DEN_W:0]     rem_sh;
   logic [i4q_pkg::DIV_DEN_W:0]     rem_sub;
   logic                            ge;

   assign rem_sh  = {rem_ff, quo_ff[i4q_pkg::DIV_NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign ge      = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = i4q_pkg::DIV_CNT_W'(i4q_pkg::DIV_NUM_W - 1);
         quo_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[i4q_pkg::DIV_DEN_W-1:0] : rem_sh[i4q_pkg::DIV_DEN_W-1:0];
         quo_in = {quo_ff[i4q_pkg::DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff - i4q_pkg::DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

/* design/int4_absmax_quantizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int4_absmax_quantizer
// Loads one tensor of 16-bit samples into a RAM, then emits packed int4 codes.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the block is loading; each is written
// to the sample RAM and the running absmax is updated. A sample flagged last,
// or the sample that fills the RAM, ends the tensor and input stalls until all
// packed bytes are produced. The scale round(absmax*256/7) is computed in
// ST_SCALE by a constant reciprocal multiply. Each sample then passes ST_RD
// for the RAM read, ST_DIV to start the 19-step radix-2 divider and ST_WAIT
// for the division and rounding; each packed byte then passes ST_PACK, which
// loads the output register and holds while it is full. The divider sets
// the pace: a sample is read only after the prior division is done. The
// final byte may wait in the output register while the next tensor loads.
// ----------------------------------------------------------------------------
module int4_absmax_quantizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  i4q_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output i4q_pkg::rsp_type rsp_data
);

   typedef enum logic [5:0] {
      ST_LOAD       = 6'b000001,
      ST_SCALE      = 6'b000010,
      ST_RD         = 6'b000100,
      ST_DIV        = 6'b001000,
      ST_WAIT       = 6'b010000,
      ST_PACK       = 6'b100000
   } state_type;

   state_type                        state_ff, state_in;
   logic [i4q_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [i4q_pkg::MAG_W-1:0]        absmax_ff, absmax_in;
   logic [i4q_pkg::ADDR_W-1:0]       idx_ff, idx_in;
   logic [i4q_pkg::SCALE_W-1:0]      scale_ff, scale_in;
   logic [i4q_pkg::CODE_W-1:0]       lo_ff, lo_in;
   logic [i4q_pkg::CODE_W-1:0]       hi_ff, hi_in;
   logic                             sign_ff, sign_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   i4q_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                             req_take;
   logic                             end_tensor;
   logic [i4q_pkg::MAG_W-1:0]        req_mag;
   logic [i4q_pkg::CNT_W-1:0]        idx_next;
   logic                             idx_is_last;
   logic                             out_free;
   logic                             out_load;

   logic                             ram_wr_en;
   logic                             ram_rd_en;
   logic [i4q_pkg::WEIGHT_W-1:0]     ram_rd_data;
   logic [i4q_pkg::MAG_W-1:0]        rd_mag;
   logic [i4q_pkg::MUL7_W-1:0]       rd_mag7;

   logic [i4q_pkg::SCALE_NUM_W-1:0]  scale_num;
   logic [i4q_pkg::SCALE_PROD_W-1:0] scale_prod;

   i4q_pkg::div_req_type             div_req;
   i4q_pkg::div_rsp_type             div_rsp;
   logic                             round_up;
   logic [i4q_pkg::CODE_W:0]         q_round;
   logic [i4q_pkg::CODE_W-1:0]       code;

   i4q_ram #(
      .WIDTH(i4q_pkg::WEIGHT_W),
      .DEPTH(i4q_pkg::MAX_ELEMENTS)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[i4q_pkg::ADDR_W-1:0]),
      .wr_data (req_data.weight),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   i4q_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_take   = req_valid && !req_stall;
   assign req_mag    = i4q_pkg::abs_mag(req_data.weight);
   assign end_tensor = req_data.last_weight ||
                       (count_ff == i4q_pkg::CNT_W'(i4q_pkg::MAX_ELEMENTS - 1));
   assign ram_wr_en  = req_take;
   assign ram_rd_en  = (state_ff == ST_RD);

   assign idx_next    = i4q_pkg::CNT_W'(idx_ff) + i4q_pkg::CNT_W'(1);
   assign idx_is_last = (idx_next >= count_ff);

   // round(absmax*256/7) as (absmax*256 + 3) * ceil(2^27/7) >> 27
   assign scale_num  = {absmax_ff, i4q_pkg::FRAC_W'(0)} + i4q_pkg::SCALE_ROUND;
   assign scale_prod = i4q_pkg::SCALE_PROD_W'(scale_num) *
                       i4q_pkg::SCALE_PROD_W'(i4q_pkg::SCALE_RECIP);

   // 7 * |w| from the sample just read
   assign rd_mag  = i4q_pkg::abs_mag(ram_rd_data);
   assign rd_mag7 = (i4q_pkg::MUL7_W'(rd_mag) << 3) - i4q_pkg::MUL7_W'(rd_mag);

   // round half to even on quotient and remainder of 7|w| / absmax
   assign round_up = ({div_rsp.rem, 1'b0} > {1'b0, absmax_ff}) ||
                     (({div_rsp.rem, 1'b0} == {1'b0, absmax_ff}) && div_rsp.quo[0]);
   assign q_round  = {1'b0, div_rsp.quo[i4q_pkg::CODE_W-1:0]} +
                     (i4q_pkg::CODE_W + 1)'(round_up);
   assign code     = (absmax_ff == '0) ? '0 : i4q_pkg::code_nibble(q_round, sign_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == ST_PACK) && out_free;

   always_comb begin
      div_req.start = (state_ff == ST_DIV);
      div_req.num   = i4q_pkg::DIV_NUM_W'(rd_mag7);
      div_req.den   = absmax_ff;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      absmax_in    = absmax_ff;
      idx_in       = idx_ff;
      scale_in     = scale_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      sign_in      = sign_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               count_in = count_ff + i4q_pkg::CNT_W'(1);
               if (req_mag > absmax_ff) begin
                  absmax_in = req_mag;
               end
               if (end_tensor) begin
                  state_in = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            scale_in = scale_prod[i4q_pkg::SCALE_SHIFT +: i4q_pkg::SCALE_W];
            idx_in   = '0;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            sign_in  = ram_rd_data[i4q_pkg::WEIGHT_W-1];
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               if (!idx_ff[0]) begin
                  lo_in = code;
                  if (idx_is_last) begin
                     // odd count: pad the high nibble
                     hi_in    = '0;
                     state_in = ST_PACK;
                  end else begin
                     idx_in   = idx_next[i4q_pkg::ADDR_W-1:0];
                     state_in = ST_RD;
                  end
               end else begin
                  hi_in    = code;
                  state_in = ST_PACK;
               end
            end
         end
         ST_PACK: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.packed_byte   = {hi_ff, lo_ff};
               rsp_data_in.scale_fixed   = scale_ff;
               rsp_data_in.element_count = i4q_pkg::COUNT_W'(count_ff);
               rsp_data_in.last_byte     = idx_is_last;
               if (idx_is_last) begin
                  count_in  = '0;
                  absmax_in = '0;
                  state_in  = ST_LOAD;
               end else begin
                  idx_in   = idx_next[i4q_pkg::ADDR_W-1:0];
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         absmax_ff    <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         absmax_ff    <= absmax_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scale_ff    <= scale_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      sign_ff     <= sign_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sample count never runs past the RAM depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= i4q_pkg::CNT_W'(i4q_pkg::MAX_ELEMENTS))
      else $error("sample count exceeds capacity");

   // reads stay inside the loaded part of the tensor
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD |-> i4q_pkg::CNT_W'(idx_ff) < count_ff)
      else $error("read index beyond loaded samples");

   // divider completes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_WAIT)
      else $error("unexpected divider completion");

   // a byte loaded into the output register shows up next cycle
   assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("packed byte lost at output register");

   // a finished tensor leaves the state cleared for the next one
   assert property (@(posedge clock) disable iff (reset)
      out_load && idx_is_last |=> state_ff == ST_LOAD && count_ff == '0 && absmax_ff == '0)
      else $error("tensor state not cleared after final byte");

endmodule

/* tb/int4_absmax_quantizer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int4_absmax_quantizer_checker
// Watches both channels of the quantizer, keeps its own copy of the sample
// store and running absmax, works out the packed bytes of every tensor as it
// closes and compares them in order with what the block emits.
// ----------------------------------------------------------------------------
module int4_absmax_quantizer_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  i4q_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  i4q_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               bytes_pending
);

   localparam int LEVELS   = 7;
   localparam int CODE_TOP = 7;
   localparam int CODE_BOT = -8;

   int               samples [i4q_pkg::MAX_ELEMENTS];
   int               fill;
   int               peak;
   i4q_pkg::rsp_type expected_bytes [$];

   // round-half-even(7*w/absmax) in exact integers, clamped to the int4 range
   function automatic logic [i4q_pkg::CODE_W-1:0] quant_code(input int w,
                                                             input int absmax);
      int mag;
      int q;
      int r;
      int c;
      if (absmax == 0) begin
         return '0;
      end
      mag = (w < 0) ? -w : w;
      q = (LEVELS * mag) / absmax;
      r = (LEVELS * mag) % absmax;
      if (2 * r > absmax || (2 * r == absmax && q % 2 == 1)) begin
         q++;
      end
      c = (w < 0) ? -q : q;
      if (c > CODE_TOP) begin
         c = CODE_TOP;
      end
      if (c < CODE_BOT) begin
         c = CODE_BOT;
      end
      return i4q_pkg::CODE_W'(c);
   endfunction

   task automatic quantize_tensor();
      int                         nbytes;
      int                         scale;
      logic [i4q_pkg::CODE_W-1:0] lo;
      logic [i4q_pkg::CODE_W-1:0] hi;
      i4q_pkg::rsp_type           e;
      nbytes = (fill + 1) / 2;
      // absmax/7 with eight fractional bits, rounded; 7 is odd so no ties
      scale = (peak * 512 + LEVELS) / (2 * LEVELS);
      for (int k = 0; k < nbytes; k++) begin
         lo = quant_code(samples[2 * k], peak);
         hi = (2 * k + 1 < fill) ? quant_code(samples[2 * k + 1], peak) : '0;
         e.packed_byte   = {hi, lo};
         e.scale_fixed   = i4q_pkg::SCALE_W'(scale);
         e.element_count = i4q_pkg::COUNT_W'(fill);
         e.last_byte     = (k == nbytes - 1);
         expected_bytes.push_back(e);
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      int               w;
      int               mag;
      i4q_pkg::rsp_type want;
      if (reset) begin
         fill = 0;
         peak = 0;
         expected_bytes.delete();
      end else begin
         if (req_valid && !req_stall) begin
            w = $signed(req_data.weight);
            mag = (w < 0) ? -w : w;
            samples[fill] = w;
            fill++;
            if (mag > peak) begin
               peak = mag;
            end
            // a full store closes the tensor even without the last flag
            if (req_data.last_weight || fill == i4q_pkg::MAX_ELEMENTS) begin
               quantize_tensor();
               fill = 0;
               peak = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected transaction: packed_byte %0h", rsp_data.packed_byte);
               mismatches++;
            end else begin
               want = expected_bytes.pop_front();
               compare_field("packed_byte", want.packed_byte, rsp_data.packed_byte);
               compare_field("scale_fixed", want.scale_fixed, rsp_data.scale_fixed);
               compare_field("element_count", want.element_count, rsp_data.element_count);
               compare_field("last_byte", want.last_byte, rsp_data.last_byte);
            end
         end
      end
      bytes_pending = expected_bytes.size();
   end

endmodule

/* tb/int4_absmax_quantizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int4_absmax_quantizer_tb
// Feeds the quantizer directed tensors (zero tensors, extreme samples, rounding
// ties) and then random tensors of mixed sizes, including ones that fill the
// store, with bursty input and a stalling output. The checker does the scoring.
// ----------------------------------------------------------------------------
module int4_absmax_quantizer_tb;

   localparam int ITEM_TARGET     = 430;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 2000;
   localparam int DRAIN_CYCLES    = 100;

   typedef enum int {FULL_RANGE, NEAR_ZERO, ALL_ZERO, EXTREMES, MIXED} weight_flavor_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   i4q_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   i4q_pkg::rsp_type rsp_data;

   int mismatches;
   int bytes_pending;
   int items_sent;
   int burst_left;
   int cycle_count;
   bit offering;
   bit random_phase;
   bit hold_off_done;

   int4_absmax_quantizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   int4_absmax_quantizer_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .mismatches    (mismatches),
      .bytes_pending (bytes_pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("int4_absmax_quantizer_tb: done, errors");
      $finish;
   end

   function automatic logic [i4q_pkg::WEIGHT_W-1:0] rand_weight(
      input weight_flavor_type flavor);
      logic [i4q_pkg::WEIGHT_W-1:0] w;
      case (flavor)
         FULL_RANGE: w = i4q_pkg::WEIGHT_W'($urandom);
         NEAR_ZERO:  w = i4q_pkg::WEIGHT_W'($urandom_range(0, 40) - 20);
         ALL_ZERO:   w = '0;
         EXTREMES: begin
            w = $urandom_range(0, 1) ?
                i4q_pkg::WEIGHT_W'(16'h8000 + $urandom_range(0, 3)) :
                i4q_pkg::WEIGHT_W'(16'h7FFF - $urandom_range(0, 3));
         end
         default:    w = rand_weight(weight_flavor_type'($urandom_range(0, 3)));
      endcase
      return w;
   endfunction

   // offer one transaction, then either keep the burst going or drop valid for a gap
   task automatic send_weight(input logic [i4q_pkg::WEIGHT_W-1:0] w, input logic last);
      req_data <= {w, last};
      req_valid <= 1'b1;
      offering = 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         offering = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 20);
      end
   endtask

   // receiver: phases of differing stall density, one long hold-off
   initial begin
      int span;
      int odds;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         if (random_phase && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         span = $urandom_range(20, 150);
         case ($urandom_range(0, 3))
            0:       odds = 0;
            1:       odds = 30;
            2:       odds = 60;
            default: odds = 85;
         endcase
         repeat (span) begin
            rsp_stall <= ($urandom_range(0, 99) < odds);
            @(negedge clock);
         end
      end
   end

   initial begin
      int                len;
      int                tensor_idx;
      bit                open_end;
      weight_flavor_type flavor;
      items_sent = 0;
      burst_left = $urandom_range(0, 20);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single zero sample, odd count
      send_weight(16'h0000, 1'b1);
      // all-zero tensor
      send_weight(16'h0000, 1'b0);
      send_weight(16'h0000, 1'b0);
      send_weight(16'h0000, 1'b0);
      send_weight(16'h0000, 1'b1);
      // most negative sample sets absmax to 32768
      send_weight(16'h8000, 1'b0);
      send_weight(16'h7FFF, 1'b0);
      send_weight(16'h0001, 1'b0);
      send_weight(16'hFFFF, 1'b0);
      send_weight(16'hC000, 1'b1);
      // absmax 14: halves land on ties
      send_weight(16'd14, 1'b0);
      send_weight(16'd1, 1'b0);
      send_weight(16'd3, 1'b0);
      send_weight(16'd5, 1'b0);
      send_weight(-16'sd5, 1'b0);
      send_weight(16'd7, 1'b1);
      // largest positive magnitude
      send_weight(16'h7FFF, 1'b0);
      send_weight(16'h8001, 1'b1);

      random_phase = 1'b1;
      tensor_idx = 0;
      while (items_sent < ITEM_TARGET) begin
         if (tensor_idx == 2 || $urandom_range(0, 29) == 0) begin
            len = i4q_pkg::MAX_ELEMENTS;
         end else if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(13, 40);
         end else begin
            len = $urandom_range(1, 12);
         end
         // keep the total close to the item target
         if (len > ITEM_TARGET - items_sent) begin
            len = ITEM_TARGET - items_sent;
         end
         // the store filling up must close the tensor on its own
         open_end = (len == i4q_pkg::MAX_ELEMENTS) &&
                    (tensor_idx == 2 || $urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: flavor = FULL_RANGE;
            4, 5:       flavor = NEAR_ZERO;
            6:          flavor = ALL_ZERO;
            7:          flavor = EXTREMES;
            default:    flavor = MIXED;
         endcase
         for (int i = 0; i < len; i++) begin
            send_weight(rand_weight(flavor), (i == len - 1) && !open_end);
         end
         tensor_idx++;
      end

      if (offering) begin
         req_valid <= 1'b0;
      end
      while (bytes_pending != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("int4_absmax_quantizer_tb: done, clean");
      end else begin
         $display("int4_absmax_quantizer_tb: done, errors");
      end
      $finish;
   end

endmodule
